@@ sv/vertex_normal_accumulator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared concurrent assertion forms, sampled on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define VNA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VNA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Widths, request and response types, action codes.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VNA_VERTICES = 1024;
    localparam int IDX_W        = $clog2(VNA_VERTICES);
    localparam int POS_W        = 16;
    localparam int NRM_W        = 16;
    localparam int NRM_FRAC     = 14;
    localparam int POS_WORD_W   = 3 * POS_W;
    localparam int NRM_WORD_W   = 3 * NRM_W;
    localparam int EDGE_W       = POS_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int SUM_W        = NRM_W + 1;
    localparam int MAG_LIM_W    = 30;
    localparam int SQ_W         = 2 * MAG_LIM_W + 2;
    localparam int ROOT_STEPS   = SQ_W / 2;
    localparam int ROOT_W       = MAG_LIM_W + 1;
    localparam int QUO_W        = NRM_FRAC + 1;
    localparam int REM_W        = NRM_FRAC + MAG_LIM_W;
    localparam int DEN_W        = NRM_FRAC + ROOT_W;
    localparam int THIRD_MUL    = 21846;
    localparam int THIRD_SHIFT  = 16;
    localparam int THIRD_W      = 2 * QUO_W;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TRI  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef logic signed [CROSS_W-1:0] t_comp;
    typedef logic signed [NRM_W-1:0]   t_nrm;

    typedef struct packed {
        t_action                  action;
        logic [IDX_W-1:0]         vertex_index;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [IDX_W-1:0]         corner_first;
        logic [IDX_W-1:0]         corner_second;
        logic [IDX_W-1:0]         corner_third;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] which_vertex;
        t_nrm             norm_x;
        t_nrm             norm_y;
        t_nrm             norm_z;
    } t_rsp;

endpackage

@@ sv/vna_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vna_ram import vna_pkg::*; #(
    parameter int WIDTH = NRM_WORD_W,
    parameter int DEPTH = VNA_VERTICES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vna_norm.sv @@
// ----------------------------------------------------------------------------
// Vector normalize unit
// Prescale, sum of squares, bit-serial square root, three restoring dividers.
// ----------------------------------------------------------------------------
module vna_norm import vna_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_comp i_vec [3],
    output logic  o_done,
    output t_nrm  o_res [3]
);

    typedef enum logic [4:0] {
        N_IDLE  = 5'b00001,
        N_SHIFT = 5'b00010,
        N_SQ    = 5'b00100,
        N_ROOT  = 5'b01000,
        N_DIV   = 5'b10000
    } t_nstate;

    t_nstate              r_state;
    logic [CROSS_W-1:0]   r_mag [3];
    logic                 r_neg [3];
    logic [4:0]           r_cnt;
    logic [SQ_W-1:0]      r_acc;
    logic [SQ_W-1:0]      r_root;
    logic [DEN_W-1:0]     r_den;
    logic [REM_W-1:0]     r_rem [3];
    logic [QUO_W-1:0]     r_quo [3];
    logic                 r_done;
    t_nrm                 r_res [3];

    logic                      w_big;
    logic [2*MAG_LIM_W-1:0]    w_sq;
    logic [SQ_W-1:0]           w_bit;
    logic [SQ_W-1:0]           w_trial;
    logic                      w_take;
    logic [SQ_W-1:0]           w_root_nx;
    logic [SQ_W-1:0]           w_acc_nx;
    logic                      w_zero;
    logic                      w_ge [3];
    logic [REM_W-1:0]          w_rem_nx [3];
    logic [QUO_W-1:0]          w_quo_nx [3];
    t_nrm                      w_q [3];

    always_comb begin
        w_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_big = w_big | (|r_mag[i][CROSS_W-1:MAG_LIM_W]);
        end
        w_sq      = r_mag[r_cnt[1:0]][MAG_LIM_W-1:0] * r_mag[r_cnt[1:0]][MAG_LIM_W-1:0];
        w_bit     = SQ_W'(1) << {r_cnt, 1'b0};
        w_trial   = r_root + w_bit;
        w_take    = (r_acc >= w_trial);
        w_root_nx = w_take ? ((r_root >> 1) + w_bit) : (r_root >> 1);
        w_acc_nx  = w_take ? (r_acc - w_trial) : r_acc;
        w_zero    = (r_root == '0);
        for (int i = 0; i < 3; i++) begin
            w_ge[i]     = ({1'b0, r_rem[i]} >= r_den);
            w_rem_nx[i] = w_ge[i] ? REM_W'({1'b0, r_rem[i]} - r_den) : r_rem[i];
            w_quo_nx[i] = {r_quo[i][QUO_W-2:0], w_ge[i]};
            w_q[i]      = t_nrm'({1'b0, w_quo_nx[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (!w_big) begin
                        r_state <= N_SQ;
                        r_cnt   <= '0;
                    end
                end
                N_SQ: begin
                    if (r_cnt == 5'd2) begin
                        r_state <= N_ROOT;
                        r_cnt   <= 5'(ROOT_STEPS - 1);
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                N_ROOT: begin
                    if (r_cnt == '0) begin
                        r_state <= N_DIV;
                        r_cnt   <= 5'(QUO_W - 1);
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                N_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= N_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= i_vec[i][CROSS_W-1];
                        r_mag[i] <= i_vec[i][CROSS_W-1] ? CROSS_W'(-i_vec[i])
                                                        : CROSS_W'(i_vec[i]);
                    end
                end
            end
            N_SHIFT: begin
                if (w_big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end else begin
                    r_acc <= '0;
                end
            end
            N_SQ: begin
                r_acc <= r_acc + SQ_W'(w_sq);
                if (r_cnt == 5'd2) begin
                    r_root <= '0;
                end
            end
            N_ROOT: begin
                r_acc  <= w_acc_nx;
                r_root <= w_root_nx;
                if (r_cnt == '0) begin
                    r_den <= DEN_W'(w_root_nx[ROOT_W-1:0]) << NRM_FRAC;
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= {r_mag[i][MAG_LIM_W-1:0], {NRM_FRAC{1'b0}}};
                        r_quo[i] <= '0;
                    end
                end
            end
            N_DIV: begin
                r_den <= r_den >> 1;
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= w_rem_nx[i];
                    r_quo[i] <= w_quo_nx[i];
                    if (r_cnt == '0) begin
                        r_res[i] <= w_zero ? '0 : (r_neg[i] ? -w_q[i] : w_q[i]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ sv/vertex_normal_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Load: written when accepted. Read: through the normal RAM read register into
// the output register. Triangle: paced by the shared normalize unit (31-step
// square root, 15-step divide) run once for the face and once per corner.
// Reset: a sweep zeroes all 1024 normal store entries; requests stall meanwhile.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit import vna_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_RD     = 12'b000000000100,
        S_TP0    = 12'b000000001000,
        S_TP1    = 12'b000000010000,
        S_TP2    = 12'b000000100000,
        S_TEDGE  = 12'b000001000000,
        S_TCROSS = 12'b000010000000,
        S_TFACE  = 12'b000100000000,
        S_CRD    = 12'b001000000000,
        S_CSUM   = 12'b010000000000,
        S_CNORM  = 12'b100000000000
    } t_state;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_clr_idx;
    logic [IDX_W-1:0]         r_vidx;
    logic [IDX_W-1:0]         r_c [3];
    logic [1:0]               r_j;
    logic [2:0]               r_k;
    logic [POS_WORD_W-1:0]    r_pos [3];
    logic signed [EDGE_W-1:0] r_ea [3];
    logic signed [EDGE_W-1:0] r_eb [3];
    t_comp                    r_cr [3];
    t_nrm                     r_third [3];
    logic signed [SUM_W-1:0]  r_sum [3];
    logic                     r_nstart;
    logic                     r_out_valid;
    t_rsp                     r_out;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_pos_we, w_pos_re;
    logic [IDX_W-1:0]         w_pos_raddr;
    logic [POS_WORD_W-1:0]    w_pos_rdata;
    logic                     w_nrm_we, w_nrm_re;
    logic [IDX_W-1:0]         w_nrm_waddr, w_nrm_raddr;
    logic [NRM_WORD_W-1:0]    w_nrm_wdata, w_nrm_rdata;
    t_comp                    w_nvec [3];
    logic                     w_ndone;
    t_nrm                     w_nres [3];
    logic signed [EDGE_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [POS_W-1:0]  w_p [3][3];
    t_nrm                     w_rn [3];
    logic [QUO_W-1:0]         w_tmag [3];
    logic [THIRD_W-1:0]       w_tprod [3];
    t_nrm                     w_tq [3];
    t_nrm                     w_third [3];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == IDX_W'(VNA_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && i_in_req.action == ACT_TRI) begin
                    n_state = S_TP0;
                end else if (w_in_acc && i_in_req.action == ACT_READ) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TP0:   n_state = S_TP1;
            S_TP1:   n_state = S_TP2;
            S_TP2:   n_state = S_TEDGE;
            S_TEDGE: n_state = S_TCROSS;
            S_TCROSS: begin
                if (r_k == 3'd5) begin
                    n_state = S_TFACE;
                end
            end
            S_TFACE: begin
                if (w_ndone) begin
                    n_state = S_CRD;
                end
            end
            S_CRD:  n_state = S_CSUM;
            S_CSUM: n_state = S_CNORM;
            S_CNORM: begin
                if (w_ndone) begin
                    n_state = (r_j == 2'd2) ? S_IDLE : S_CRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        w_pos_we    = w_in_acc && (i_in_req.action == ACT_LOAD);
        w_pos_re    = (w_in_acc && (i_in_req.action == ACT_TRI))
                      || (r_state == S_TP0) || (r_state == S_TP1);
        case (r_state)
            S_TP0:   w_pos_raddr = r_c[1];
            S_TP1:   w_pos_raddr = r_c[2];
            default: w_pos_raddr = i_in_req.corner_first;
        endcase

        w_nrm_we    = (r_state == S_CLEAR) || w_pos_we || ((r_state == S_CNORM) && w_ndone);
        w_nrm_wdata = '0;
        case (r_state)
            S_CLEAR: w_nrm_waddr = r_clr_idx;
            S_CNORM: begin
                w_nrm_waddr = r_c[r_j];
                w_nrm_wdata = {w_nres[0], w_nres[1], w_nres[2]};
            end
            default: w_nrm_waddr = i_in_req.vertex_index;
        endcase
        w_nrm_re    = (w_in_acc && (i_in_req.action == ACT_READ)) || (r_state == S_CRD);
        w_nrm_raddr = (r_state == S_CRD) ? r_c[r_j] : i_in_req.vertex_index;
    end

    // datapath helpers
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
                w_p[v][i] = $signed(r_pos[v][(2-i)*POS_W +: POS_W]);
            end
        end
        case (r_k)
            3'd0:    begin w_ma = r_eb[1]; w_mb = r_ea[2]; end
            3'd1:    begin w_ma = r_eb[2]; w_mb = r_ea[1]; end
            3'd2:    begin w_ma = r_eb[2]; w_mb = r_ea[0]; end
            3'd3:    begin w_ma = r_eb[0]; w_mb = r_ea[2]; end
            3'd4:    begin w_ma = r_eb[0]; w_mb = r_ea[1]; end
            3'd5:    begin w_ma = r_eb[1]; w_mb = r_ea[0]; end
            default: begin w_ma = r_eb[0]; w_mb = r_ea[0]; end
        endcase
        w_prod = w_ma * w_mb;
        for (int i = 0; i < 3; i++) begin
            w_rn[i]    = $signed(w_nrm_rdata[(2-i)*NRM_W +: NRM_W]);
            w_tmag[i]  = w_nres[i][NRM_W-1] ? QUO_W'(-w_nres[i]) : QUO_W'(w_nres[i]);
            w_tprod[i] = w_tmag[i] * QUO_W'(THIRD_MUL);
            w_tq[i]    = t_nrm'(w_tprod[i] >> THIRD_SHIFT);
            w_third[i] = w_nres[i][NRM_W-1] ? -w_tq[i] : w_tq[i];
            w_nvec[i]  = (r_state == S_CNORM) ? t_comp'(r_sum[i]) : r_cr[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_nstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nstart <= ((r_state == S_TCROSS) && (r_k == 3'd5)) || (r_state == S_CSUM);
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (w_out_free) begin
                r_out_valid <= (r_state == S_RD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_vidx <= i_in_req.vertex_index;
                    r_c[0] <= i_in_req.corner_first;
                    r_c[1] <= i_in_req.corner_second;
                    r_c[2] <= i_in_req.corner_third;
                end
            end
            S_RD: begin
                if (w_out_free) begin
                    r_out.which_vertex <= r_vidx;
                    r_out.norm_x       <= w_rn[0];
                    r_out.norm_y       <= w_rn[1];
                    r_out.norm_z       <= w_rn[2];
                end
            end
            S_TP0: r_pos[0] <= w_pos_rdata;
            S_TP1: r_pos[1] <= w_pos_rdata;
            S_TP2: r_pos[2] <= w_pos_rdata;
            S_TEDGE: begin
                r_k <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_ea[i] <= EDGE_W'(w_p[2][i]) - EDGE_W'(w_p[0][i]);
                    r_eb[i] <= EDGE_W'(w_p[1][i]) - EDGE_W'(w_p[0][i]);
                end
            end
            S_TCROSS: begin
                r_k <= r_k + 3'd1;
                if (!r_k[0]) begin
                    r_cr[r_k[2:1]] <= t_comp'(w_prod);
                end else begin
                    r_cr[r_k[2:1]] <= r_cr[r_k[2:1]] - t_comp'(w_prod);
                end
            end
            S_TFACE: begin
                if (w_ndone) begin
                    r_j     <= '0;
                    r_third <= w_third;
                end
            end
            S_CSUM: begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= SUM_W'(w_rn[i]) + SUM_W'(r_third[i]);
                end
            end
            S_CNORM: begin
                if (w_ndone) begin
                    r_j <= r_j + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    vna_ram #(
        .WIDTH (POS_WORD_W),
        .DEPTH (VNA_VERTICES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (i_in_req.vertex_index),
        .i_wdata ({i_in_req.pos_x, i_in_req.pos_y, i_in_req.pos_z}),
        .i_re    (w_pos_re),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    vna_ram #(
        .WIDTH (NRM_WORD_W),
        .DEPTH (VNA_VERTICES)
    ) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    (w_nrm_we),
        .i_waddr (w_nrm_waddr),
        .i_wdata (w_nrm_wdata),
        .i_re    (w_nrm_re),
        .i_raddr (w_nrm_raddr),
        .o_rdata (w_nrm_rdata)
    );

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (w_nvec),
        .o_done  (w_ndone),
        .o_res   (w_nres)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

@@ sv/vna_checker.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_unit_macros.svh"

module vna_checker import vna_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_req i_in_req,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_rsp
);

    logic w_acc;
    logic w_rd_acc;
    logic w_tri_acc;
    logic w_held;
    logic w_x_ok;
    assign w_acc     = i_in_valid && !o_in_stall;
    assign w_rd_acc  = w_acc && (i_in_req.action == ACT_READ);
    assign w_tri_acc = w_acc && (i_in_req.action == ACT_TRI);
    assign w_held    = o_out_valid && i_out_stall;
    assign w_x_ok    = (o_out_rsp.norm_x <= 16'sd16384) && (o_out_rsp.norm_x >= -16'sd16384);

    `VNA_ASSERT_NEXT(a_out_hold, w_held, o_out_valid && $stable(o_out_rsp), "stalled response changed")
    `VNA_ASSERT_NEXT(a_read_busy, w_rd_acc, o_in_stall, "read request not held off")
    `VNA_ASSERT_NEXT(a_tri_busy, w_tri_acc, o_in_stall, "triangle request not held off")
    `VNA_ASSERT_NOW(a_norm_range, o_out_valid, w_x_ok, "normal x out of range")

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (.*);
